### hw/rtl/fbc_pkg.sv
// Shared constants and types for the frustum box cull block.
package fbc_pkg;

   localparam int COORD_WIDTH_DEF = 16;
   localparam int PLANE_COUNT_DEF = 6;

   // planes that have a configuration register
   localparam int REG_COUNT   = 6;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;

   localparam int COEF_W        = 16;
   localparam int COEF_COUNT    = 4;
   localparam int AXIS_COUNT    = 3;
   localparam int FIELD_COUNT   = 2 * AXIS_COUNT;
   localparam int D_ALIGN_SHIFT = 8;

   localparam int VERDICT_W  = 2;
   localparam int RSP_DATA_W = 8;

   typedef enum logic [VERDICT_W-1:0] {
      VERDICT_DISJOINT   = 2'd0,
      VERDICT_INTERSECTS = 2'd1,
      VERDICT_CONTAINS   = 2'd2
   } verdict_type;

   // running classification carried along the cell chain
   typedef struct packed {
      logic disjoint;
      logic straddle;
   } flags_type;

endpackage

### hw/rtl/fbc_cell.sv
// One plane cell: holds a plane, tests a box against it, passes box and flags on.
module fbc_cell #(
   parameter int COORD_WIDTH = fbc_pkg::COORD_WIDTH_DEF,
   parameter int INDEX       = 0
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr,
   input  logic [fbc_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [fbc_pkg::CSR_DATA_W-1:0]        csr_data,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  logic signed [COORD_WIDTH-1:0]         in_box [fbc_pkg::FIELD_COUNT],
   input  fbc_pkg::flags_type                    in_flags,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output logic signed [COORD_WIDTH-1:0]         out_box [fbc_pkg::FIELD_COUNT],
   output fbc_pkg::flags_type                    out_flags
);

   localparam int PROD_W = fbc_pkg::COEF_W + COORD_WIDTH;
   localparam int DIST_W = PROD_W + 2;
   localparam int DPAD_W = DIST_W - fbc_pkg::COEF_W - fbc_pkg::D_ALIGN_SHIFT;
   localparam logic [fbc_pkg::CSR_INDEX_W-1:0] MY_INDEX = fbc_pkg::CSR_INDEX_W'(INDEX);
   localparam bit HAS_REG = (INDEX < fbc_pkg::REG_COUNT);

   logic [fbc_pkg::CSR_DATA_W-1:0] plane_ff, plane_in;
   logic signed [fbc_pkg::COEF_W-1:0] coef [fbc_pkg::COEF_COUNT];

   logic                           valid_a_ff, valid_b_ff;
   logic                           ready_a, ready_b;
   logic signed [COORD_WIDTH-1:0]  box_a_ff [fbc_pkg::FIELD_COUNT];
   logic signed [COORD_WIDTH-1:0]  box_b_ff [fbc_pkg::FIELD_COUNT];
   fbc_pkg::flags_type             flags_a_ff, flags_b_ff, flags_b_in;
   logic signed [PROD_W-1:0]       prod_lo_ff [fbc_pkg::AXIS_COUNT];
   logic signed [PROD_W-1:0]       prod_hi_ff [fbc_pkg::AXIS_COUNT];
   logic signed [PROD_W-1:0]       prod_lo_in [fbc_pkg::AXIS_COUNT];
   logic signed [PROD_W-1:0]       prod_hi_in [fbc_pkg::AXIS_COUNT];
   logic signed [DIST_W-1:0]       dist_max, dist_min;
   logic signed [DIST_W-1:0]       d_term;
   logic                           all_out;

   // plane register
   always_comb begin
      plane_in = plane_ff;
      if (HAS_REG && csr_wr && csr_index == MY_INDEX) begin
         plane_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_ff <= '0;
      end else begin
         plane_ff <= plane_in;
      end
   end

   always_comb begin
      for (int k = 0; k < fbc_pkg::COEF_COUNT; k++) begin
         coef[k] = plane_ff[fbc_pkg::COEF_W*k +: fbc_pkg::COEF_W];
      end
   end

   assign ready_b  = !valid_b_ff || out_ready;
   assign ready_a  = !valid_a_ff || ready_b;
   assign in_ready = ready_a;

   // stage A: per-axis products at both box extremes
   always_comb begin
      for (int i = 0; i < fbc_pkg::AXIS_COUNT; i++) begin
         prod_lo_in[i] = PROD_W'(coef[i]) * PROD_W'(in_box[i]);
         prod_hi_in[i] = PROD_W'(coef[i]) * PROD_W'(in_box[i + fbc_pkg::AXIS_COUNT]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else if (ready_a) begin
         valid_a_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_a && in_valid) begin
         box_a_ff   <= in_box;
         flags_a_ff <= in_flags;
         prod_lo_ff <= prod_lo_in;
         prod_hi_ff <= prod_hi_in;
      end
   end

   // stage B: extreme corner distances are sums of per-axis extremes
   assign d_term = {{DPAD_W{coef[3][fbc_pkg::COEF_W-1]}}, coef[3],
                    {fbc_pkg::D_ALIGN_SHIFT{1'b0}}};

   always_comb begin
      dist_max = d_term;
      dist_min = d_term;
      for (int i = 0; i < fbc_pkg::AXIS_COUNT; i++) begin
         if (prod_hi_ff[i] > prod_lo_ff[i]) begin
            dist_max = dist_max + DIST_W'(prod_hi_ff[i]);
            dist_min = dist_min + DIST_W'(prod_lo_ff[i]);
         end else begin
            dist_max = dist_max + DIST_W'(prod_lo_ff[i]);
            dist_min = dist_min + DIST_W'(prod_hi_ff[i]);
         end
      end
      all_out             = dist_max[DIST_W-1];
      flags_b_in.disjoint = flags_a_ff.disjoint || all_out;
      flags_b_in.straddle = flags_a_ff.straddle || (dist_min[DIST_W-1] && !all_out);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_b_ff <= 1'b0;
      end else if (ready_b) begin
         valid_b_ff <= valid_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_b && valid_a_ff) begin
         box_b_ff   <= box_a_ff;
         flags_b_ff <= flags_b_in;
      end
   end

   assign out_valid = valid_b_ff;
   assign out_box   = box_b_ff;
   assign out_flags = flags_b_ff;

endmodule

### hw/rtl/frustum_box_cull.sv
// Frustum box cull: one rsp word per accepted req word. Throughput one box per cycle
// while rsp_tready holds; each plane cell has a product stage and a sum stage.
// Every stage register has its own valid, so bubbles close up and input keeps flowing
// while a finished verdict waits at the output, until all 2*PLANE_COUNT stages hold a word.
// Synchronous active-high reset empties the pipeline and clears all planes to zero.
module frustum_box_cull #(
   parameter int COORD_WIDTH = fbc_pkg::COORD_WIDTH_DEF,
   parameter int PLANE_COUNT = fbc_pkg::PLANE_COUNT_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // min_x, min_y, min_z, max_x, max_y, max_z, zero pad
   input  logic [((fbc_pkg::FIELD_COUNT*COORD_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // verdict, zero pad
   output logic [fbc_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [fbc_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [fbc_pkg::CSR_DATA_W-1:0]         csr_data
);

   logic                          chain_valid [PLANE_COUNT+1];
   logic                          chain_ready [PLANE_COUNT+1];
   logic signed [COORD_WIDTH-1:0] chain_box   [PLANE_COUNT+1][fbc_pkg::FIELD_COUNT];
   fbc_pkg::flags_type            chain_flags [PLANE_COUNT+1];
   fbc_pkg::verdict_type          verdict;

   assign csr_ready = 1'b1;

   assign chain_valid[0]          = req_tvalid;
   assign req_tready              = chain_ready[0];
   assign chain_flags[0].disjoint = 1'b0;
   assign chain_flags[0].straddle = 1'b0;

   for (genvar f = 0; f < fbc_pkg::FIELD_COUNT; f++) begin : g_req_field
      assign chain_box[0][f] = req_tdata[COORD_WIDTH*f +: COORD_WIDTH];
   end

   for (genvar i = 0; i < PLANE_COUNT; i++) begin : g_cell
      fbc_cell #(
         .COORD_WIDTH (COORD_WIDTH),
         .INDEX       (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .csr_wr    (csr_valid),
         .csr_index (csr_index),
         .csr_data  (csr_data),
         .in_valid  (chain_valid[i]),
         .in_ready  (chain_ready[i]),
         .in_box    (chain_box[i]),
         .in_flags  (chain_flags[i]),
         .out_valid (chain_valid[i+1]),
         .out_ready (chain_ready[i+1]),
         .out_box   (chain_box[i+1]),
         .out_flags (chain_flags[i+1])
      );
   end

   // last cell's sum stage is the output register
   assign chain_ready[PLANE_COUNT] = rsp_tready;
   assign rsp_tvalid               = chain_valid[PLANE_COUNT];

   always_comb begin
      if (chain_flags[PLANE_COUNT].disjoint) begin
         verdict = fbc_pkg::VERDICT_DISJOINT;
      end else if (chain_flags[PLANE_COUNT].straddle) begin
         verdict = fbc_pkg::VERDICT_INTERSECTS;
      end else begin
         verdict = fbc_pkg::VERDICT_CONTAINS;
      end
   end

   assign rsp_tdata = {{(fbc_pkg::RSP_DATA_W-fbc_pkg::VERDICT_W){1'b0}}, verdict};

endmodule

### hw/rtl/fbc_checker.sv
// Port-level checks for the frustum box cull block, bound to the top level.
module fbc_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [fbc_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // a held word keeps its verdict
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp word changed while stalled");

   a_verdict_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[1:0] != 2'd3 &&
                     rsp_tdata[fbc_pkg::RSP_DATA_W-1:fbc_pkg::VERDICT_W] == '0)
      else $error("bad verdict code");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid right after reset");

   // an empty output stage frees the whole chain
   a_empty_accepts: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("req stalled with empty output");

endmodule

bind frustum_box_cull fbc_checker u_fbc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

### tb/frustum_box_cull_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for frustum_box_cull: directed and random boxes against plane sets.
module frustum_box_cull_tb;

   localparam int COORD_W        = fbc_pkg::COORD_WIDTH_DEF;
   localparam int PLANES         = fbc_pkg::PLANE_COUNT_DEF;
   localparam int COEF_W         = fbc_pkg::COEF_W;
   localparam int SETTLE         = 2 * PLANES + 4;
   localparam int COORD_MAX      = 2 ** (COORD_W - 1) - 1;
   localparam int COORD_MIN      = -(2 ** (COORD_W - 1));
   localparam int COEF_MAX       = 2 ** (COEF_W - 1) - 1;
   localparam int COEF_MIN       = -(2 ** (COEF_W - 1));
   localparam int Q12_ONE        = 4096;
   localparam int PHASES         = 6;
   localparam int ITEMS_PER_PHASE = 48;

   typedef enum logic [fbc_pkg::CSR_INDEX_W-1:0] {
      PLANE_NEAR   = 3'd0,
      PLANE_FAR    = 3'd1,
      PLANE_LEFT   = 3'd2,
      PLANE_RIGHT  = 3'd3,
      PLANE_TOP    = 3'd4,
      PLANE_BOTTOM = 3'd5,
      CSR_SPARE_LO = 3'd6,
      CSR_SPARE_HI = 3'd7
   } plane_index_type;

   // first member sits in the highest bits, so min_x lands at bit 0
   typedef struct packed {
      logic signed [COORD_W-1:0] max_z, max_y, max_x, min_z, min_y, min_x;
   } box_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] d, c, b, a;
   } plane_type;

   logic                                 clock      = 1'b0;
   logic                                 reset      = 1'b1;
   logic                                 req_tvalid = 1'b0;
   logic                                 req_tready;
   logic [$bits(box_type)-1:0]           req_tdata  = '0;
   logic                                 rsp_tvalid;
   logic                                 rsp_tready = 1'b0;
   logic [fbc_pkg::RSP_DATA_W-1:0]       rsp_tdata;
   logic                                 csr_valid  = 1'b0;
   logic                                 csr_ready;
   logic [fbc_pkg::CSR_INDEX_W-1:0]      csr_index  = '0;
   logic [fbc_pkg::CSR_DATA_W-1:0]       csr_data   = '0;

   plane_type            plane_model [PLANES];
   fbc_pkg::verdict_type pending_verdicts [$];
   int                   send_idle_pct = 0;
   int                   rsp_idle_pct  = 0;
   int                   error_count   = 0;

   frustum_box_cull #(
      .COORD_WIDTH(COORD_W),
      .PLANE_COUNT(PLANES)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   function automatic fbc_pkg::verdict_type cull_box(input box_type box);
      fbc_pkg::verdict_type verdict;
      logic                 disjoint;
      longint               distance, x, y, z;
      int                   n_out;
      verdict  = fbc_pkg::VERDICT_CONTAINS;
      disjoint = 1'b0;
      for (int p = 0; p < PLANES; p++) begin
         n_out = 0;
         for (int k = 0; k < 8; k++) begin
            x = longint'(k[0] ? box.max_x : box.min_x);
            y = longint'(k[1] ? box.max_y : box.min_y);
            z = longint'(k[2] ? box.max_z : box.min_z);
            distance = longint'(plane_model[p].a) * x + longint'(plane_model[p].b) * y
                     + longint'(plane_model[p].c) * z
                     + (longint'(plane_model[p].d) <<< fbc_pkg::D_ALIGN_SHIFT);
            // zero distance counts as inside
            if (distance < 0) n_out++;
         end
         if (n_out == 8) begin
            disjoint = 1'b1;
         end else if (n_out != 0) begin
            verdict = fbc_pkg::VERDICT_INTERSECTS;
         end
      end
      return disjoint ? fbc_pkg::VERDICT_DISJOINT : verdict;
   endfunction

   // check the rsp word first, then track csr writes and predict accepted req words
   always @(posedge clock) begin
      fbc_pkg::verdict_type want;
      if (reset) begin
         foreach (plane_model[i]) plane_model[i] = '0;
         pending_verdicts.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_verdicts.size() == 0) begin
               error_count++;
               $error("rsp word with no verdict pending: actual %0d", rsp_tdata);
            end else begin
               want = pending_verdicts.pop_front();
               if (rsp_tdata[fbc_pkg::VERDICT_W-1:0] !== want) begin
                  error_count++;
                  $error("verdict: expected %0d, actual %0d", want,
                         rsp_tdata[fbc_pkg::VERDICT_W-1:0]);
               end
               if (rsp_tdata[fbc_pkg::RSP_DATA_W-1:fbc_pkg::VERDICT_W] !== '0) begin
                  error_count++;
                  $error("pad: expected 0, actual %0d",
                         rsp_tdata[fbc_pkg::RSP_DATA_W-1:fbc_pkg::VERDICT_W]);
               end
            end
         end
         if (csr_valid && csr_ready && csr_index < fbc_pkg::REG_COUNT && csr_index < PLANES)
            plane_model[csr_index] = csr_data;
         if (req_tvalid && req_tready)
            pending_verdicts.push_back(cull_box(req_tdata));
      end
   end

   function automatic box_type make_box(input int x0, y0, z0, x1, y1, z1);
      box_type box;
      box.min_x = COORD_W'(x0);
      box.min_y = COORD_W'(y0);
      box.min_z = COORD_W'(z0);
      box.max_x = COORD_W'(x1);
      box.max_y = COORD_W'(y1);
      box.max_z = COORD_W'(z1);
      return box;
   endfunction

   function automatic plane_type make_plane(input int a, b, c, d);
      plane_type plane;
      plane.a = COEF_W'(a);
      plane.b = COEF_W'(b);
      plane.c = COEF_W'(c);
      plane.d = COEF_W'(d);
      return plane;
   endfunction

   function automatic int clamp_coord(input int v);
      if (v > COORD_MAX) return COORD_MAX;
      if (v < COORD_MIN) return COORD_MIN;
      return v;
   endfunction

   function automatic int extreme_coord();
      case ($urandom_range(4))
         0: return COORD_MIN;
         1: return COORD_MAX;
         2: return 0;
         3: return -1;
         default: return 1;
      endcase
   endfunction

   function automatic int extreme_coef();
      case ($urandom_range(6))
         0: return COEF_MIN;
         1: return COEF_MAX;
         2: return 0;
         3: return -1;
         4: return 1;
         5: return Q12_ONE;
         default: return -Q12_ONE;
      endcase
   endfunction

   function automatic box_type random_box();
      box_type box;
      int      lo [fbc_pkg::AXIS_COUNT];
      int      hi [fbc_pkg::AXIS_COUNT];
      int      center, half;
      case ($urandom_range(9))
         0: begin
            // arbitrary bits, min above max in about half the axes
            box = {$urandom, $urandom, $urandom};
            return box;
         end
         1: begin
            for (int i = 0; i < fbc_pkg::AXIS_COUNT; i++) begin
               lo[i] = extreme_coord();
               hi[i] = extreme_coord();
            end
         end
         2: begin
            for (int i = 0; i < fbc_pkg::AXIS_COUNT; i++) begin
               lo[i] = int'($urandom_range(0, 65535)) + COORD_MIN;
               hi[i] = lo[i];
            end
         end
         default: begin
            for (int i = 0; i < fbc_pkg::AXIS_COUNT; i++) begin
               center = int'($urandom_range(0, 6000)) - 3000;
               half   = $urandom_range(0, 1500);
               lo[i]  = clamp_coord(center - half);
               hi[i]  = clamp_coord(center + half);
            end
         end
      endcase
      return make_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
   endfunction

   function automatic plane_type random_plane();
      plane_type plane;
      int        axis;
      plane = '0;
      case ($urandom_range(5))
         0: plane = '0;
         1: plane = {$urandom, $urandom};
         2: begin
            for (int k = 0; k < fbc_pkg::COEF_COUNT; k++)
               plane[COEF_W*k +: COEF_W] = COEF_W'(extreme_coef());
         end
         3: begin
            for (int k = 0; k < fbc_pkg::COEF_COUNT; k++)
               plane[COEF_W*k +: COEF_W] = COEF_W'(int'($urandom_range(0, 8192)) - Q12_ONE);
         end
         default: begin
            axis = $urandom_range(fbc_pkg::AXIS_COUNT - 1);
            plane[COEF_W*axis +: COEF_W] = COEF_W'($urandom_range(0, 1) ?
               int'($urandom_range(1024, 8192)) : -int'($urandom_range(1024, 8192)));
            plane.d = COEF_W'(int'($urandom_range(0, 65535)) + COEF_MIN);
         end
      endcase
      return plane;
   endfunction

   // one face of an axis-aligned cube around the origin, slightly tilted
   function automatic plane_type cube_plane(input int face);
      plane_type plane;
      int        axis;
      axis  = face / 2;
      plane = '0;
      for (int k = 0; k < fbc_pkg::AXIS_COUNT; k++)
         plane[COEF_W*k +: COEF_W] = COEF_W'(int'($urandom_range(0, 512)) - 256);
      plane[COEF_W*axis +: COEF_W] = COEF_W'((face % 2) ? -Q12_ONE : Q12_ONE);
      plane.d = COEF_W'($urandom_range(0, 3) == 0 ? COEF_MAX :
                        int'($urandom_range(1024, COEF_MAX)));
      return plane;
   endfunction

   // lower valid, let every verdict drain, then give the pipeline time to empty
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending_verdicts.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_plane(input plane_index_type index, input plane_type value);
      wait_idle();
      csr_index <= index;
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // valid stays high into the next word when no gap is drawn
   task automatic send_box(input box_type box);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tdata  <= box;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   // planes are all zero after reset, so every box is contained
   task automatic test_reset_planes();
      send_box(make_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
      send_box(make_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
      send_box(make_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
      send_box(make_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN));
      send_box(make_box(0, 0, 0, 0, 0, 0));
   endtask

   // writes past the last plane register must leave the planes alone
   task automatic test_spare_index();
      write_plane(CSR_SPARE_LO, make_plane(0, 0, 0, -1));
      write_plane(CSR_SPARE_HI, '1);
      send_box(make_box(-256, -256, -256, 256, 256, 256));
      send_box(make_box(COORD_MIN, 0, COORD_MAX, COORD_MAX, 0, COORD_MIN));
   endtask

   task automatic test_plane_edges();
      // z >= 0
      write_plane(PLANE_NEAR, make_plane(0, 0, Q12_ONE, 0));
      send_box(make_box(-100, -100, 0, 100, 100, 256));
      send_box(make_box(-100, -100, -1, 100, 100, 1));
      send_box(make_box(-100, -100, -256, 100, 100, -1));
      send_box(make_box(100, 100, 5, -100, -100, -5));
      // constant negative distance puts every corner outside
      write_plane(PLANE_TOP, make_plane(0, 0, 0, -1));
      send_box(make_box(0, 0, 0, 256, 256, 256));
      write_plane(PLANE_NEAR, make_plane(COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX));
      write_plane(PLANE_FAR, make_plane(COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN));
      write_plane(PLANE_LEFT, make_plane(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX));
      write_plane(PLANE_RIGHT, make_plane(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN));
      write_plane(PLANE_TOP, '0);
      write_plane(PLANE_BOTTOM, make_plane(0, 0, 0, COEF_MAX));
      send_box(make_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
      send_box(make_box(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN));
      send_box(make_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
      send_box(make_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
      send_box(make_box(0, 0, 0, 0, 0, 0));
      send_box(make_box(-1, -1, -1, 1, 1, 1));
   endtask

   task automatic test_random(input int send_pct, input int rsp_pct);
      plane_type planes [PLANES];
      logic      cube;
      send_idle_pct = send_pct;
      rsp_idle_pct  = rsp_pct;
      for (int phase = 0; phase < PHASES; phase++) begin
         cube = ($urandom_range(9) < 6);
         foreach (planes[i]) planes[i] = cube ? cube_plane(i) : random_plane();
         foreach (planes[i]) write_plane(plane_index_type'(i), planes[i]);
         repeat (ITEMS_PER_PHASE) send_box(random_box());
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 35;
      rsp_idle_pct  = 88;
      test_reset_planes();
      test_spare_index();
      test_plane_edges();
      test_random(35, 88);
      test_random(88, 35);
      test_random(0, 0);
      wait_idle();
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

### sim.f
hw/rtl/fbc_pkg.sv
hw/rtl/fbc_cell.sv
hw/rtl/frustum_box_cull.sv
hw/rtl/fbc_checker.sv
tb/frustum_box_cull_tb.sv
